@@ rtl/core/sf2d_pkg.sv @@
`default_nettype none

package sf2d_pkg;

    // Build-time defaults and fixed field widths
    localparam int MAX_DIM     = 1024;
    localparam int KERNEL_ROWS = 3;
    localparam int KERNEL_COLS = 3;

    // Half-extent of the mask in each direction (a size of 1 drops that border)
    localparam int TRAVEL_R = (KERNEL_ROWS >= 2) ? 1 : 0;
    localparam int TRAVEL_C = (KERNEL_COLS >= 2) ? 1 : 0;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int DIM_REG_W  = 11;
    localparam int COEF_REG_W = 48;
    localparam int POS_W      = 10;
    localparam int SUM_W      = 28;
    // |pixel * coef| <= 255 * 32768, fits 24 bits signed
    localparam int PROD_W     = 24;
    localparam int COL_W      = PROD_W + 2;

    typedef logic [2:0][2:0][PIX_W-1:0] t_window;   // [row: oldest..newest][col: c-2..c]
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [COL_W-1:0]    t_col_sum;

    typedef struct packed {
        logic [COEF_REG_W-1:0] left;
        logic [COEF_REG_W-1:0] mid;
        logic [COEF_REG_W-1:0] right;
    } t_coefs;

    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } t_meta;

    // True when a window tap takes part in the sum
    function automatic logic tap_used(input logic [1:0] wr, input logic [1:0] wc);
        return ((TRAVEL_R != 0) || (wr == 2'd2)) && ((TRAVEL_C != 0) || (wc == 2'd2));
    endfunction

    // Pick the coefficient that goes with a window tap
    function automatic logic signed [COEF_W-1:0] coef_pick(
        input t_coefs     c,
        input logic [1:0] wr,
        input logic [1:0] wc
    );
        logic [COEF_REG_W-1:0] reg_sel;
        logic [1:0]            col;
        logic [1:0]            slot;
        col  = (TRAVEL_C != 0) ? wc : 2'd1;
        slot = (TRAVEL_R != 0) ? wr : 2'd1;
        unique case (col)
            2'd0:    reg_sel = c.left;
            2'd1:    reg_sel = c.mid;
            default: reg_sel = c.right;
        endcase
        unique case (slot)
            2'd0:    return signed'(reg_sel[COEF_W-1:0]);
            2'd1:    return signed'(reg_sel[2*COEF_W-1:COEF_W]);
            default: return signed'(reg_sel[3*COEF_W-1:2*COEF_W]);
        endcase
    endfunction

    // Unsigned pixel times signed coefficient, exact
    function automatic t_prod mul_tap(
        input logic [PIX_W-1:0]         pix,
        input logic signed [COEF_W-1:0] coef
    );
        logic signed [PROD_W:0] a;
        logic signed [PROD_W:0] b;
        logic signed [PROD_W:0] p;
        a = signed'({{(PROD_W + 1 - PIX_W){1'b0}}, pix});
        b = signed'({{(PROD_W + 1 - COEF_W){coef[COEF_W-1]}}, coef});
        p = a * b;
        return signed'(p[PROD_W-1:0]);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sf2d_mac.sv @@
`default_nettype none

module sf2d_mac (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire sf2d_pkg::t_window   i_win,
    input  wire sf2d_pkg::t_coefs    i_coef,
    input  wire sf2d_pkg::t_meta     i_meta,
    output logic                     o_valid,
    input  wire                      i_ready,
    output sf2d_pkg::t_col_sum       o_col_sum [3],
    output sf2d_pkg::t_meta          o_meta
);

    logic                r_v3;
    logic                r_v4;
    sf2d_pkg::t_prod     r_prod [3][3];
    sf2d_pkg::t_prod     n_prod [3][3];
    sf2d_pkg::t_col_sum  r_col_sum [3];
    sf2d_pkg::t_col_sum  n_col_sum [3];
    sf2d_pkg::t_meta     r_meta3;
    sf2d_pkg::t_meta     r_meta4;
    logic                en3;
    logic                en4;

    // Advance a stage when it is empty or its successor moves
    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;

    // Nine tap products
    always_comb begin
        for (int wr = 0; wr < 3; wr++) begin
            for (int wc = 0; wc < 3; wc++) begin
                if (sf2d_pkg::tap_used(2'(wr), 2'(wc))) begin
                    n_prod[wr][wc] = sf2d_pkg::mul_tap(i_win[wr][wc],
                        sf2d_pkg::coef_pick(i_coef, 2'(wr), 2'(wc)));
                end else begin
                    n_prod[wr][wc] = '0;
                end
            end
        end
    end

    // Sum each mask column
    always_comb begin
        for (int wc = 0; wc < 3; wc++) begin
            n_col_sum[wc] = sf2d_pkg::COL_W'(r_prod[0][wc])
                          + sf2d_pkg::COL_W'(r_prod[1][wc])
                          + sf2d_pkg::COL_W'(r_prod[2][wc]);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en3) r_v3 <= i_valid;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en3 && i_valid) begin
            r_prod  <= n_prod;
            r_meta3 <= i_meta;
        end
        if (en4 && r_v3) begin
            r_col_sum <= n_col_sum;
            r_meta4   <= r_meta3;
        end
    end

    assign o_valid   = r_v4;
    assign o_col_sum = r_col_sum;
    assign o_meta    = r_meta4;

endmodule

`default_nettype wire

@@ rtl/core/spatial_filter_2d.sv @@
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------
// pixel    | in        | i_valid / o_stall  | i_pixel
// result   | out       | o_valid / i_stall  | o_filtered_value, o_out_col, o_out_row,
//          |           |                    | o_last
// config   | in        | i_cfg_wr_en        | i_cfg_index, i_cfg_data
//
// One pixel is taken every cycle while o_stall is low; o_filtered_value is registered.
// One line memory with two registered read ports; a pixel reads both column
// buffers and writes its own slot in the same cycle, so no forwarding is needed.
// Reset (synchronous, active low) clears counters, window and valid bits, not
// the line memory. A stalled result holds while up to four more results queue
// behind it; border pixels that give no result keep flowing and are dropped.

`default_nettype none

module spatial_filter_2d #(
    parameter int MAX_DIM = sf2d_pkg::MAX_DIM
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_valid,
    output logic                                      o_stall,
    input  wire  [sf2d_pkg::PIX_W-1:0]                i_pixel,
    output logic                                      o_valid,
    input  wire                                       i_stall,
    output logic signed [sf2d_pkg::SUM_W-1:0]         o_filtered_value,
    output logic [sf2d_pkg::POS_W-1:0]                o_out_col,
    output logic [sf2d_pkg::POS_W-1:0]                o_out_row,
    output logic                                      o_last,
    input  wire                                       i_cfg_wr_en,
    input  wire  [2:0]                                i_cfg_index,
    input  wire  [sf2d_pkg::COEF_REG_W-1:0]           i_cfg_data
);

    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int EW      = (CNT_W + 1 > sf2d_pkg::DIM_REG_W) ? CNT_W + 1
                                                               : sf2d_pkg::DIM_REG_W;
    localparam int MEM_DEPTH = 2 ** (CNT_W + 1);

    typedef enum logic [2:0] {
        CFG_HEIGHT     = 3'd0,
        CFG_WIDTH      = 3'd1,
        CFG_COEF_LEFT  = 3'd2,
        CFG_COEF_MID   = 3'd3,
        CFG_COEF_RIGHT = 3'd4
    } t_cfg_idx;

    // Configuration registers
    logic [sf2d_pkg::DIM_REG_W-1:0] r_height;
    logic [sf2d_pkg::DIM_REG_W-1:0] r_width;
    sf2d_pkg::t_coefs               r_coef;

    // Position counters
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] n_row;
    logic [CNT_W-1:0] n_col;

    // Line store
    logic [sf2d_pkg::PIX_W-1:0] r_line_mem [MEM_DEPTH];
    logic [CNT_W:0]             wr_addr;
    logic [CNT_W:0]             prev_addr;

    // Pipeline
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v5;
    logic [sf2d_pkg::PIX_W-1:0] r_rd_older;
    logic [sf2d_pkg::PIX_W-1:0] r_rd_prev;
    logic [sf2d_pkg::PIX_W-1:0] r_px1;
    sf2d_pkg::t_meta            r_meta1;
    sf2d_pkg::t_meta            r_meta2;
    sf2d_pkg::t_meta            n_meta;
    sf2d_pkg::t_window          r_win;
    logic signed [sf2d_pkg::SUM_W-1:0] r_sum;
    logic [sf2d_pkg::POS_W-1:0] r_out_col;
    logic [sf2d_pkg::POS_W-1:0] r_out_row;
    logic                       r_out_last;

    logic                       en1;
    logic                       en2;
    logic                       en5;
    logic                       in_accept;
    logic                       mac_ready;
    logic                       mac_valid;
    sf2d_pkg::t_col_sum         mac_col_sum [3];
    sf2d_pkg::t_meta            mac_meta;

    logic [EW-1:0]              h_ext;
    logic [EW-1:0]              w_ext;
    logic [EW-1:0]              h_eff;
    logic [EW-1:0]              w_eff;
    logic                       row_end;
    logic                       col_end;
    logic [CNT_W-1:0]           row_ctr;
    logic [CNT_W-1:0]           col_ctr;

    // Handshake: each stage moves when empty or when its successor moves; a window stage with no result also moves
    assign en5       = !r_v5 || !i_stall;
    assign en2       = !r_v2 || !r_meta2.emit || mac_ready;
    assign en1       = !r_v1 || en2;
    assign o_stall   = !en1;
    assign in_accept = i_valid && en1;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= sf2d_pkg::DIM_REG_W'(1024);
            r_width  <= sf2d_pkg::DIM_REG_W'(1024);
            r_coef   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_HEIGHT:     r_height     <= i_cfg_data[sf2d_pkg::DIM_REG_W-1:0];
                CFG_WIDTH:      r_width      <= i_cfg_data[sf2d_pkg::DIM_REG_W-1:0];
                CFG_COEF_LEFT:  r_coef.left  <= i_cfg_data;
                CFG_COEF_MID:   r_coef.mid   <= i_cfg_data;
                CFG_COEF_RIGHT: r_coef.right <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Clamp image sizes to 1..MAX_DIM
    always_comb begin
        h_ext = EW'(r_height);
        w_ext = EW'(r_width);
        priority if (h_ext == '0)             h_eff = EW'(1);
        else if (h_ext > EW'(MAX_DIM))        h_eff = EW'(MAX_DIM);
        else                                  h_eff = h_ext;
        priority if (w_ext == '0)             w_eff = EW'(1);
        else if (w_ext > EW'(MAX_DIM))        w_eff = EW'(MAX_DIM);
        else                                  w_eff = w_ext;
    end

    assign row_end = (EW'(r_row) + EW'(1)) >= h_eff;
    assign col_end = (EW'(r_col) + EW'(1)) >= w_eff;
    assign row_ctr = r_row - CNT_W'(sf2d_pkg::TRAVEL_R);
    assign col_ctr = r_col - CNT_W'(sf2d_pkg::TRAVEL_C);

    // Next position and result tag for the incoming pixel
    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        if (row_end) begin
            n_row = '0;
            n_col = col_end ? '0 : r_col + CNT_W'(1);
        end else begin
            n_row = r_row + CNT_W'(1);
        end
        n_meta.emit = (EW'(r_row) >= EW'(2 * sf2d_pkg::TRAVEL_R))
                   && (EW'(r_col) >= EW'(2 * sf2d_pkg::TRAVEL_C));
        n_meta.col  = sf2d_pkg::POS_W'(col_ctr);
        n_meta.row  = sf2d_pkg::POS_W'(row_ctr);
        n_meta.last = row_end && col_end;
    end

    // Advance counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Read both column buffers and overwrite the older one
    assign wr_addr   = {r_col[0], r_row};
    assign prev_addr = {~r_col[0], r_row};

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_older          <= r_line_mem[wr_addr];
            r_rd_prev           <= r_line_mem[prev_addr];
            r_line_mem[wr_addr] <= i_pixel;
        end
    end

    // Stage valid bits and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v5  <= 1'b0;
            r_win <= '0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en5) r_v5 <= mac_valid;
            // Shift window rows and load the newest row
            if (en2 && r_v1) begin
                r_win[0]    <= r_win[1];
                r_win[1]    <= r_win[2];
                r_win[2][0] <= r_rd_older;
                r_win[2][1] <= r_rd_prev;
                r_win[2][2] <= r_px1;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_px1   <= i_pixel;
            r_meta1 <= n_meta;
        end
        if (en2 && r_v1) begin
            r_meta2 <= r_meta1;
        end
    end

    sf2d_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v2 && r_meta2.emit),
        .o_ready   (mac_ready),
        .i_win     (r_win),
        .i_coef    (r_coef),
        .i_meta    (r_meta2),
        .o_valid   (mac_valid),
        .i_ready   (en5),
        .o_col_sum (mac_col_sum),
        .o_meta    (mac_meta)
    );

    // Final sum into the output register
    always_ff @(posedge i_clk) begin
        if (en5 && mac_valid) begin
            r_sum      <= sf2d_pkg::SUM_W'(mac_col_sum[0])
                        + sf2d_pkg::SUM_W'(mac_col_sum[1])
                        + sf2d_pkg::SUM_W'(mac_col_sum[2]);
            r_out_col  <= mac_meta.col;
            r_out_row  <= mac_meta.row;
            r_out_last <= mac_meta.last;
        end
    end

    assign o_valid          = r_v5;
    assign o_filtered_value = r_sum;
    assign o_out_col        = r_out_col;
    assign o_out_row        = r_out_row;
    assign o_last           = r_out_last;

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (EW'(r_row) < EW'(MAX_DIM)) && (EW'(r_col) < EW'(MAX_DIM)))
        else $error("position counter beyond MAX_DIM");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v5 && i_stall && r_v1 && r_v2))
        else $error("input stalled while pipeline has room");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_v1)
        else $error("accepted pixel lost at first stage");
`endif

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sf2d_pkg::*;

    localparam int RESET_CYCLES     = 4;
    localparam int MAX_GAP          = 4;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PIXELS    = 400;
    localparam int PRESSURE_AFTER   = 200;

    localparam logic [COEF_W-1:0] COEF_MOST_NEG = 16'h8000;
    localparam logic [COEF_W-1:0] COEF_MOST_POS = 16'h7FFF;

    typedef enum logic [2:0] {
        REG_HEIGHT     = 3'd0,
        REG_WIDTH      = 3'd1,
        REG_COEF_LEFT  = 3'd2,
        REG_COEF_MID   = 3'd3,
        REG_COEF_RIGHT = 3'd4
    } cfg_reg_e;

    typedef enum int {PIX_RANDOM, PIX_FULL, PIX_MIXED} pix_style_e;

    typedef struct {
        logic signed [SUM_W-1:0] value;
        logic [POS_W-1:0]        col;
        logic [POS_W-1:0]        row;
        logic                    last;
    } filter_result_t;

    // Block ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [PIX_W-1:0]          i_pixel = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [SUM_W-1:0]   o_filtered_value;
    logic [POS_W-1:0]          o_out_col;
    logic [POS_W-1:0]          o_out_row;
    logic                      o_last;
    logic                      i_cfg_wr_en = 1'b0;
    logic [2:0]                i_cfg_index = '0;
    logic [COEF_REG_W-1:0]     i_cfg_data = '0;

    // Shadow of the register file and of the filter state
    logic [DIM_REG_W-1:0]      height_reg = 11'd1024;
    logic [DIM_REG_W-1:0]      width_reg = 11'd1024;
    logic [COEF_REG_W-1:0]     mask_reg [3] = '{default: '0};
    bit   [PIX_W-1:0]          line_px [2*MAX_DIM];
    bit   [PIX_W-1:0]          win_px [3][3];
    int unsigned               row_pos = 0;
    int unsigned               col_pos = 0;

    // Traffic bookkeeping
    logic [PIX_W-1:0]          pixel_backlog [$];
    filter_result_t            pending_filter_results [$];
    int                        pixels_queued = 0;
    int                        pixels_taken = 0;
    int                        results_seen = 0;
    int                        images_sent = 0;
    int                        reg_writes = 0;
    int                        mismatch_count = 0;
    int                        send_gap = 0;
    int                        hold_left = 0;
    int                        long_holds_asked = 0;
    int                        long_holds_done = 0;
    int                        quiet_cycles = 0;
    bit                        no_gaps = 1'b0;

    spatial_filter_2d dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_pixel          (i_pixel),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_value (o_filtered_value),
        .o_out_col        (o_out_col),
        .o_out_row        (o_out_row),
        .o_last           (o_last),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Size register as the block uses it: zero acts as one, large values clip
    function automatic int unsigned eff_dim(input logic [DIM_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic int coef_of(input logic [COEF_REG_W-1:0] column, input int slot);
        return int'($signed(column[COEF_W*slot +: COEF_W]));
    endfunction

    // Advance the window by one pixel and queue the result it completes, if any
    function automatic void convolve_pixel(input logic [PIX_W-1:0] px);
        int unsigned    h;
        int unsigned    w;
        int unsigned    r;
        int unsigned    c;
        int unsigned    own_slot;
        int unsigned    prev_slot;
        int             sum;
        filter_result_t res;
        h = eff_dim(height_reg);
        w = eff_dim(width_reg);
        r = row_pos % MAX_DIM;
        c = col_pos;
        own_slot  = (c & 1) * MAX_DIM + r;
        prev_slot = ((c + 1) & 1) * MAX_DIM + r;

        // Shift the window up one row, fill the newest row from the line buffers
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 3; j++)
                win_px[i][j] = win_px[i + 1][j];
        win_px[2][0] = line_px[own_slot];
        win_px[2][1] = line_px[prev_slot];
        win_px[2][2] = px;
        line_px[own_slot] = px;

        if (r >= 2 * TRAVEL_R && c >= 2 * TRAVEL_C) begin
            sum = 0;
            for (int dc = -TRAVEL_C; dc <= TRAVEL_C; dc++)
                for (int dr = -TRAVEL_R; dr <= TRAVEL_R; dr++)
                    sum += int'(win_px[2 - TRAVEL_R + dr][2 - TRAVEL_C + dc]) *
                           coef_of(mask_reg[dc + 1], dr + 1);
            res.value = sum[SUM_W-1:0];
            res.col   = POS_W'(c - TRAVEL_C);
            res.row   = POS_W'(r - TRAVEL_R);
            res.last  = (r + 1 >= h) && (c + 1 >= w);
            pending_filter_results.push_back(res);
        end

        // Step the position, wrapping at the end of a column and of the image
        if (r + 1 >= h) begin
            row_pos = 0;
            col_pos = (c + 1 >= w) ? 0 : c + 1;
        end else begin
            row_pos = r + 1;
        end
    endfunction

    // Pixels still needed to bring the position back to the image origin
    function automatic int pixels_left_in_image();
        int unsigned r;
        int unsigned c;
        int unsigned h;
        int unsigned w;
        int          n;
        r = row_pos;
        c = col_pos;
        h = eff_dim(height_reg);
        w = eff_dim(width_reg);
        n = 0;
        while (r != 0 || c != 0) begin
            r = r % MAX_DIM;
            if (r + 1 >= h) begin
                r = 0;
                c = (c + 1 >= w) ? 0 : c + 1;
            end else begin
                r = r + 1;
            end
            n++;
        end
        return n;
    endfunction

    function automatic logic [COEF_REG_W-1:0] random_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[COEF_REG_W-1:0];
    endfunction

    // Size value in the low bits, noise above them
    function automatic logic [COEF_REG_W-1:0] dim_word(input int v);
        logic [COEF_REG_W-1:0] word;
        word = random_word();
        word[DIM_REG_W-1:0] = DIM_REG_W'(v);
        return word;
    endfunction

    function automatic logic [COEF_REG_W-1:0] pack_column(
        input logic [COEF_W-1:0] top,
        input logic [COEF_W-1:0] middle,
        input logic [COEF_W-1:0] bottom
    );
        return {bottom, middle, top};
    endfunction

    function automatic logic [COEF_REG_W-1:0] pick_mask_column();
        case ($urandom_range(0, 5))
            0:       return pack_column(COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG);
            1:       return pack_column(COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS);
            default: return random_word();
        endcase
    endfunction

    function automatic int draw_dim();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(0, 2);
            1:       return $urandom_range(9, 24);
            default: return $urandom_range(3, 8);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Compare the result taken at this edge with the oldest expectation
    task automatic check_result();
        filter_result_t want;
        results_seen++;
        if (pending_filter_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result col %0d row %0d value %0d",
                                      o_out_col, o_out_row, o_filtered_value));
            return;
        end
        want = pending_filter_results.pop_front();
        if (o_filtered_value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d at col %0d row %0d",
                                      o_filtered_value, want.value, want.col, want.row));
        if (o_out_col !== want.col)
            report_mismatch($sformatf("col %0d, want %0d", o_out_col, want.col));
        if (o_out_row !== want.row)
            report_mismatch($sformatf("row %0d, want %0d", o_out_row, want.row));
        if (o_last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b at col %0d row %0d",
                                      o_last, want.last, want.col, want.row));
    endtask

    // Pixel driver: hold a stalled request, idle out the gap, then offer the next pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                convolve_pixel(i_pixel);
                pixels_taken++;
            end
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pixel_backlog.size() != 0) begin
                    i_pixel  <= pixel_backlog.pop_front();
                    i_valid  <= 1'b1;
                    send_gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted result, then draw the next hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_result();
                hold_left = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (long_holds_done != long_holds_asked) begin
                long_holds_done++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles with no traffic on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every pixel is taken and every result is back, then drain
    task automatic wait_idle();
        while (pixels_taken != pixels_queued || pending_filter_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [COEF_REG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        reg_writes++;
        case (idx)
            REG_HEIGHT:     height_reg  = data[DIM_REG_W-1:0];
            REG_WIDTH:      width_reg   = data[DIM_REG_W-1:0];
            REG_COEF_LEFT:  mask_reg[0] = data;
            REG_COEF_MID:   mask_reg[1] = data;
            REG_COEF_RIGHT: mask_reg[2] = data;
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(
        input int                    h,
        input int                    w,
        input logic [COEF_REG_W-1:0] left,
        input logic [COEF_REG_W-1:0] mid,
        input logic [COEF_REG_W-1:0] right
    );
        wait_idle();
        write_reg(REG_HEIGHT, dim_word(h));
        write_reg(REG_WIDTH, dim_word(w));
        write_reg(REG_COEF_LEFT, left);
        write_reg(REG_COEF_MID, mid);
        write_reg(REG_COEF_RIGHT, right);
        close_writes();
    endtask

    task automatic queue_pixels(input int count, input pix_style_e style);
        logic [PIX_W-1:0] px;
        for (int k = 0; k < count; k++) begin
            case (style)
                PIX_FULL:  px = '1;
                PIX_MIXED: px = $urandom_range(0, 1) ? '1 : '0;
                default: begin
                    case ($urandom_range(0, 15))
                        0:       px = '0;
                        1:       px = '1;
                        default: px = PIX_W'($urandom_range(0, 255));
                    endcase
                end
            endcase
            pixel_backlog.push_back(px);
            pixels_queued++;
        end
    endtask

    task automatic queue_image(input pix_style_e style);
        images_sent++;
        queue_pixels(eff_dim(height_reg) * eff_dim(width_reg), style);
    endtask

    initial begin
        int  random_pixels;
        int  h;
        int  w;
        bit  pressure_done;
        random_pixels = 0;
        pressure_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Most negative mask on full-scale pixels; indexes past the map are ignored
        set_config(3, 3, pack_column(COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG),
                   pack_column(COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG),
                   pack_column(COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG));
        for (int k = REG_COEF_RIGHT + 1; k < (1 << $bits(cfg_reg_e)); k++)
            write_reg(3'(k), random_word());
        close_writes();
        queue_image(PIX_FULL);

        // Most positive mask, pixels at both ends of the range
        set_config(3, 3, pack_column(COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS),
                   pack_column(COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS),
                   pack_column(COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS));
        queue_image(PIX_MIXED);

        // Images smaller than the mask give no results; zero sizes act as one
        set_config(2, 3, random_word(), random_word(), random_word());
        queue_image(PIX_RANDOM);
        set_config(0, 1, random_word(), random_word(), random_word());
        queue_image(PIX_RANDOM);

        // Sizes above the limit clip: run down a tall column, then cut the height
        set_config(2047, 3, random_word(), random_word(), random_word());
        images_sent++;
        queue_pixels(24, PIX_RANDOM);
        wait_idle();
        write_reg(REG_HEIGHT, dim_word(4));
        close_writes();
        queue_pixels(pixels_left_in_image(), PIX_RANDOM);

        // Wide image keeps counting columns, then the width is cut
        set_config(3, 1025, random_word(), random_word(), random_word());
        images_sent++;
        queue_pixels(30, PIX_RANDOM);
        wait_idle();
        write_reg(REG_WIDTH, dim_word(4));
        close_writes();
        queue_pixels(pixels_left_in_image(), PIX_RANDOM);

        // Width cut below the current column mid-image: column wraps at its end
        set_config(4, 8, random_word(), random_word(), random_word());
        images_sent++;
        queue_pixels(20, PIX_RANDOM);
        wait_idle();
        write_reg(REG_WIDTH, dim_word(3));
        write_reg(REG_COEF_MID, random_word());
        close_writes();
        queue_pixels(pixels_left_in_image(), PIX_RANDOM);

        // Height cut below the current row mid-column: row wraps after one pixel
        set_config(6, 5, random_word(), random_word(), random_word());
        images_sent++;
        queue_pixels(16, PIX_RANDOM);
        wait_idle();
        write_reg(REG_HEIGHT, dim_word(3));
        close_writes();
        queue_pixels(pixels_left_in_image(), PIX_RANDOM);

        // Random images, new settings on most of them, one long receiver hold
        while (random_pixels < RANDOM_PIXELS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (!pressure_done && random_pixels >= PRESSURE_AFTER) begin
                set_config(8, 8, pick_mask_column(), pick_mask_column(),
                           pick_mask_column());
                no_gaps = 1'b1;
                long_holds_asked++;
                pressure_done = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                h = draw_dim();
                w = draw_dim();
                set_config(h, w, pick_mask_column(), pick_mask_column(),
                           pick_mask_column());
            end
            queue_image(PIX_RANDOM);
            random_pixels += eff_dim(height_reg) * eff_dim(width_reg);
        end

        wait_idle();
        $display("Covered %0d pixels in %0d images with %0d register writes; %0d results compared",
                 pixels_taken, images_sent, reg_writes, results_seen);
        $display("Included clipped and degenerate sizes, mid-image size changes and a %0d-cycle hold",
                 LONG_HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
